// ===== src/srt_pkg.sv =====
// Shared types and constants for the sorted record table.
package srt_pkg;

	localparam int KEY_W    = 64;
	localparam int ID_W     = 32;
	localparam int COURSE_W = 64;
	localparam int YEAR_W   = 4;
	localparam int MODE_W   = 2;
	localparam int STAT_W   = 2;
	localparam int RIDX_W   = 4;
	localparam int ECNT_W   = 5;

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
	localparam logic [STAT_W-1:0] STAT_BAD_INDEX = 2'd3;

	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [ID_W-1:0]     id;
		logic [COURSE_W-1:0] course;
		logic [YEAR_W-1:0]   year;
	} entry_t;

	typedef struct packed {
		logic ins_en;
		logic del_en;
	} cell_ctl_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_EXEC
	} fsm_t;

endpackage

// ===== src/srt_cell.sv =====
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
module srt_cell
	import srt_pkg::*;
(
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  entry_t    new_entry,
	input  logic      occ,
	input  logic      sel,
	input  entry_t    left_entry,
	input  logic      left_le,
	input  entry_t    right_entry,
	input  logic      hit_in,
	input  entry_t    rd_in,
	output entry_t    entry_q,
	output logic      le,
	output logic      hit_out,
	output entry_t    rd_out
);

	assign le      = occ && (entry_q.key <= new_entry.key);
	assign hit_out = hit_in || (occ && (entry_q.key == new_entry.key));
	assign rd_out  = sel ? entry_q : rd_in;

	always_ff @(posedge clk) begin
		if (ctl.ins_en) begin
			// left neighbor past the insert point: shift up
			if (!left_le) begin
				entry_q <= left_entry;
			end else if (!le) begin
				entry_q <= new_entry;
			end
		end else if (ctl.del_en && hit_out) begin
			entry_q <= right_entry;
		end
	end

endmodule

// ===== src/sorted_record_table_top.sv =====
// Top level of the sorted record table: command port, control and the cell chain.
// Done is registered from the execute state; busy is high in the execute state, so a new command
//   is not accepted until that state is over. In execute every cell compares its key against
//   the command key, and the cells past the insert point or past the hit shift.
// Reset: arst_n clears the entry count, the control state and the done strobe;
//   stored entries are not cleared and are only read below the count.
module sorted_record_table_top
	import srt_pkg::*;
#(
	parameter int DEPTH        = 16,
	parameter int KEY_CHARS    = 8,
	parameter int COURSE_CHARS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [MODE_W-1:0]   mode,
	input  logic [KEY_W-1:0]    name_key,
	input  logic [ID_W-1:0]     record_id,
	input  logic [COURSE_W-1:0] course_code,
	input  logic [YEAR_W-1:0]   year_level,
	input  logic [RIDX_W-1:0]   read_index,
	output logic                done,
	output logic [STAT_W-1:0]   status,
	output logic [ECNT_W-1:0]   entry_count,
	output logic [KEY_W-1:0]    out_name,
	output logic [ID_W-1:0]     out_id,
	output logic [COURSE_W-1:0] out_course,
	output logic [YEAR_W-1:0]   out_year
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = CNT_W + RIDX_W;
	localparam logic [KEY_W-1:0] KEY_MASK =
		{KEY_W{1'b1}} << (8 * (8 - KEY_CHARS));
	localparam logic [COURSE_W-1:0] COURSE_MASK =
		{COURSE_W{1'b1}} << (8 * (8 - COURSE_CHARS));

	// Command word captured at accept
	fsm_t                state_q, state_d;
	logic [MODE_W-1:0]   mode_q;
	entry_t              cmd_q;
	logic [RIDX_W-1:0]   idx_q;
	logic [CNT_W-1:0]    count_q;

	// Result registers
	logic                done_q;
	logic [STAT_W-1:0]   status_q;
	entry_t              rdata_q;

	// Chain wiring
	entry_t              cell_q [DEPTH];
	logic                le     [DEPTH];
	logic                hit    [DEPTH];
	entry_t              rd     [DEPTH];
	cell_ctl_t           ctl;
	logic                accept;
	logic                exec;
	logic                is_full;
	logic                found;
	logic [CMP_W-1:0]    idx_ext;
	logic [CMP_W-1:0]    cnt_cmp;
	logic [CNT_W+ECNT_W-1:0] cnt_ext;
	logic [STAT_W-1:0]   status_d;
	logic [CNT_W-1:0]    count_d;
	entry_t              rdata_d;

	assign accept  = start && !busy;
	assign exec    = (state_q == FSM_EXEC);
	assign is_full = (count_q >= CNT_W'(DEPTH));
	assign found   = hit[DEPTH-1];
	assign idx_ext = CMP_W'(idx_q);
	assign cnt_cmp = CMP_W'(count_q);

	// Next state and control
	always_comb begin
		state_d = state_q;
		busy    = 1'b0;
		unique case (state_q)
			FSM_IDLE: begin
				if (start) begin
					state_d = FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				busy    = 1'b1;
				state_d = FSM_IDLE;
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the command while the chain works on it
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q        <= mode;
			cmd_q.key     <= name_key & KEY_MASK;
			cmd_q.id      <= record_id;
			cmd_q.course  <= course_code & COURSE_MASK;
			cmd_q.year    <= year_level;
			idx_q         <= read_index;
		end
	end

	// Drive the cells: inserts only with room, deletes shift only past a hit
	assign ctl.ins_en = exec && (mode_q == MODE_INSERT) && !is_full;
	assign ctl.del_en = exec && (mode_q == MODE_DELETE);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t left_e;
		logic   left_l;
		entry_t right_e;
		logic   hit_i;
		entry_t rd_i;

		if (i == 0) begin : g_first
			assign left_e = cell_q[0];
			assign left_l = 1'b1;
			assign hit_i  = 1'b0;
		end else begin : g_mid
			assign left_e = cell_q[i-1];
			assign left_l = le[i-1];
			assign hit_i  = hit[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_e = cell_q[i];
			assign rd_i    = '0;
		end else begin : g_inner
			assign right_e = cell_q[i+1];
			assign rd_i    = rd[i+1];
		end

		srt_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.new_entry   (cmd_q),
			.occ         (count_q > CNT_W'(i)),
			.sel         (idx_ext == CMP_W'(i)),
			.left_entry  (left_e),
			.left_le     (left_l),
			.right_entry (right_e),
			.hit_in      (hit_i),
			.rd_in       (rd_i),
			.entry_q     (cell_q[i]),
			.le          (le[i]),
			.hit_out     (hit[i]),
			.rd_out      (rd[i])
		);
	end

	// Result and count update for the command in execute
	always_comb begin
		status_d = STAT_OK;
		count_d  = count_q;
		rdata_d  = '0;
		unique case (mode_q)
			MODE_INSERT: begin
				if (is_full) begin
					status_d = STAT_FULL;
				end else begin
					count_d = count_q + CNT_W'(1);
				end
			end
			MODE_DELETE: begin
				if (!found) begin
					status_d = STAT_NOT_FOUND;
				end else begin
					count_d = count_q - CNT_W'(1);
				end
			end
			MODE_READ: begin
				if (idx_ext >= cnt_cmp) begin
					status_d = STAT_BAD_INDEX;
				end else begin
					rdata_d = rd[0];
				end
			end
			default: begin
				status_d = STAT_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= exec;
			if (exec) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			status_q <= status_d;
			rdata_q  <= rdata_d;
		end
	end

	assign cnt_ext     = (CNT_W + ECNT_W)'(count_q);
	assign done        = done_q;
	assign status      = status_q;
	assign entry_count = cnt_ext[ECNT_W-1:0];
	assign out_name    = rdata_q.key;
	assign out_id      = rdata_q.id;
	assign out_course  = rdata_q.course;
	assign out_year    = rdata_q.year;

endmodule

// ===== src/srt_checker.sv =====
// Port-level checks for the sorted record table and their binding.
module srt_checker
	import srt_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input logic [STAT_W-1:0]   status,
	input logic [KEY_W-1:0]    out_name,
	input logic [ID_W-1:0]     out_id,
	input logic [COURSE_W-1:0] out_course,
	input logic [YEAR_W-1:0]   out_year
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted command did not raise busy");

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done && !busy)
		else $error("execute cycle not followed by a result");

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a command in execute");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != STAT_OK) |->
			(out_name == '0) && (out_id == '0) && (out_course == '0) && (out_year == '0))
		else $error("failed command returned nonzero data");

endmodule

bind sorted_record_table_top srt_checker u_srt_checker (.*);
